FILE: src/ucr_pkg.sv
// ucr_pkg: shared constants, coefficient struct and back-end state type for the
// uniform Catmull-Rom tessellator. No dependencies.

package ucr_pkg;

    localparam int MAX_SAMPLES_DEF = 64;
    localparam int COORD_W         = 32;
    localparam int CFG_W           = 7;
    localparam int IDX_W           = 6;
    localparam int QUOT_W          = 42;  // integer part of running terms
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [CFG_W-1:0] SAMPLES_RESET = 7'd16;
    localparam logic [1:0]       SEEN_FULL     = 2'd3;

    // per-axis segment coefficients (a = 2*p1 is carried as p1)
    typedef struct packed {
        logic signed [31:0] p1;
        logic signed [32:0] b;
        logic signed [35:0] c;
        logic signed [34:0] d;
    } t_coef;

    typedef enum logic [3:0] {
        B_IDLE,
        B_MUL1,
        B_MUL2,
        B_DIVST,
        B_DIV,
        B_CALC,
        B_SQ,
        B_SUM,
        B_ROOT,
        B_OUT
    } t_bstate;

endpackage

FILE: src/ucr_if.sv
// Handshake channels for control points in and curve samples out.
// Depends on ucr_pkg for field widths.

interface ucr_point_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [ucr_pkg::COORD_W-1:0]     point_x;
    logic signed [ucr_pkg::COORD_W-1:0]     point_y;
    logic signed [ucr_pkg::COORD_W-1:0]     point_z;

    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface ucr_sample_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [ucr_pkg::COORD_W-1:0]     sample_x;
    logic signed [ucr_pkg::COORD_W-1:0]     sample_y;
    logic signed [ucr_pkg::COORD_W-1:0]     sample_z;
    logic        [ucr_pkg::COORD_W-1:0]     chord_length;
    logic        [ucr_pkg::IDX_W-1:0]       sample_index;
    logic                                   last_sample;

    modport source (output valid, sample_x, sample_y, sample_z, chord_length,
                    sample_index, last_sample, input ready);
    modport sink   (input valid, sample_x, sample_y, sample_z, chord_length,
                    sample_index, last_sample, output ready);
endinterface

FILE: src/ucr_front.sv
// ucr_front: point window, sample-count register and segment coefficients.
// Depends on ucr_pkg and ucr_point_if; pushes segment jobs to ucr_fifo.

module ucr_front #(
    parameter int MAX_SAMPLES = ucr_pkg::MAX_SAMPLES_DEF,
    parameter int DW          = $clog2(MAX_SAMPLES),
    parameter int JW          = 3 * $bits(ucr_pkg::t_coef) + DW
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ucr_pkg::CFG_W-1:0]   i_cfg_wdata,
    ucr_point_if.sink                   i_point,
    output logic                        o_push_valid,
    output logic [JW-1:0]               o_push_data,
    input  logic                        i_push_ready
);

    logic signed [31:0]          r_p0 [3];
    logic signed [31:0]          r_p1 [3];
    logic signed [31:0]          r_p2 [3];
    logic signed [31:0]          pin  [3];
    logic [1:0]                  r_seen;
    logic [ucr_pkg::CFG_W-1:0]   r_samples;
    logic                        accept;
    logic [8:0]                  cfg9;
    logic [8:0]                  n9;
    logic [8:0]                  d9;
    ucr_pkg::t_coef [2:0]        coefs;

    assign pin[0] = i_point.point_x;
    assign pin[1] = i_point.point_y;
    assign pin[2] = i_point.point_z;

    assign i_point.ready = (r_seen != ucr_pkg::SEEN_FULL) || i_push_ready;
    assign accept        = i_point.valid && i_point.ready;
    assign o_push_valid  = i_point.valid && (r_seen == ucr_pkg::SEEN_FULL);

    // clamp sample count to [2, MAX_SAMPLES]; job carries D = n-1
    always_comb begin
        cfg9 = {2'b00, r_samples};
        if (cfg9 < 9'd2) begin
            n9 = 9'd2;
        end else if (cfg9 > 9'(MAX_SAMPLES)) begin
            n9 = 9'(MAX_SAMPLES);
        end else begin
            n9 = cfg9;
        end
        d9 = n9 - 9'd1;
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            coefs[k].p1 = r_p1[k];
            coefs[k].b  = 33'(r_p2[k]) - 33'(r_p0[k]);
            coefs[k].c  = (36'(r_p0[k]) <<< 1) - (36'(r_p1[k]) <<< 2) - 36'(r_p1[k])
                        + (36'(r_p2[k]) <<< 2) - 36'(pin[k]);
            coefs[k].d  = 35'(r_p1[k]) + (35'(r_p1[k]) <<< 1) - 35'(r_p0[k])
                        - 35'(r_p2[k]) - (35'(r_p2[k]) <<< 1) + 35'(pin[k]);
        end
    end

    assign o_push_data = {coefs, d9[DW-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_samples <= ucr_pkg::SAMPLES_RESET;
        end else if (i_cfg_we) begin
            r_samples <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 2'd0;
            for (int k = 0; k < 3; k++) begin
                r_p0[k] <= '0;
                r_p1[k] <= '0;
                r_p2[k] <= '0;
            end
        end else if (accept) begin
            if (r_seen != ucr_pkg::SEEN_FULL) begin
                r_seen <= r_seen + 2'd1;
            end
            for (int k = 0; k < 3; k++) begin
                r_p0[k] <= r_p1[k];
                r_p1[k] <= r_p2[k];
                r_p2[k] <= pin[k];
            end
        end
    end

    a_fill_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_seen != ucr_pkg::SEEN_FULL) |=> (r_seen == $past(r_seen) + 2'd1))
        else $error("window fill count did not advance");

endmodule

FILE: src/ucr_fifo.sv
// ucr_fifo: short register queue between the front and back of the tessellator.
// No package dependency.

module ucr_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  logic [W-1:0]    i_push_data,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output logic [W-1:0]    o_pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          push;
    logic          pop;

    assign o_push_ready = (r_cnt != CW'(DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue count beyond depth");

endmodule

FILE: src/ucr_div.sv
// ucr_div: bit-serial signed floor divider, one quotient bit per cycle.
// Used by ucr_back for the per-segment difference terms. No package dependency.

module ucr_div #(
    parameter int XW = 52,
    parameter int RW = 19,
    parameter int QW = 42
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [XW-1:0] i_num,
    input  logic [RW-1:0]        i_den,
    output logic                 o_done,
    output logic signed [QW-1:0] o_q,
    output logic [RW-1:0]        o_r
);

    localparam int CW = $clog2(XW + 1);

    logic          r_busy;
    logic          r_done;
    logic          r_neg;
    logic [CW-1:0] r_cnt;
    logic [XW-1:0] r_num;
    logic [RW-1:0] r_rem;
    logic [RW-1:0] r_den;
    logic signed [QW-1:0] r_q;
    logic [RW-1:0] r_r;
    logic [RW:0]   sh;
    logic          ge;
    logic [RW:0]   diff;
    logic [XW:0]   qw;
    logic          rz;

    assign sh   = {r_rem, r_num[XW-1]};
    assign diff = sh - {1'b0, r_den};
    assign ge   = (sh >= {1'b0, r_den});
    assign rz   = (r_rem == '0);

    // floor result for a negative dividend: -q when exact, else ~q = -q-1
    always_comb begin
        if (!r_neg) begin
            qw = {1'b0, r_num};
        end else if (rz) begin
            qw = -{1'b0, r_num};
        end else begin
            qw = ~{1'b0, r_num};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(XW);
            end else if (r_busy) begin
                if (r_cnt != '0) begin
                    r_cnt <= r_cnt - CW'(1);
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[XW-1];
            r_num <= i_num[XW-1] ? XW'(-i_num) : XW'(i_num);
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_rem <= ge ? diff[RW-1:0] : sh[RW-1:0];
                r_num <= {r_num[XW-2:0], ge};
            end else begin
                r_q <= qw[QW-1:0];
                r_r <= (r_neg && !rz) ? r_den - r_rem : r_rem;
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;
    assign o_r    = r_r;

endmodule

FILE: src/ucr_sqrt.sv
// ucr_sqrt: bit-serial integer square root of a 64-bit value, rounded to
// nearest and saturated to 32 bits. No package dependency.

module ucr_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_val,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic        r_busy;
    logic        r_fin;
    logic        r_done;
    logic [4:0]  r_k;
    logic [63:0] r_rem;
    logic [63:0] r_res;
    logic [31:0] r_root;
    logic [63:0] bitv;
    logic [63:0] trial;
    logic [32:0] rnd;

    assign bitv  = 64'd1 << {r_k, 1'b0};
    assign trial = r_res + bitv;
    assign rnd   = r_res[32:0] + 33'(r_rem > r_res);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_fin  <= 1'b0;
            end else if (r_busy && !r_fin) begin
                if (r_k == 5'd0) begin
                    r_fin <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_val;
            r_res <= '0;
            r_k   <= 5'd31;
        end else if (r_busy && !r_fin) begin
            if (r_rem >= trial) begin
                r_rem <= r_rem - trial;
                r_res <= (r_res >> 1) + bitv;
            end else begin
                r_res <= r_res >> 1;
            end
            r_k <= r_k - 5'd1;
        end else if (r_fin) begin
            r_root <= rnd[32] ? 32'hFFFF_FFFF : rnd[31:0];
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

FILE: src/ucr_back.sv
// ucr_back: per-segment setup, forward-difference sample stepping with exact
// quotient/remainder tracking, chord length and the output register.
// Depends on ucr_pkg, ucr_sample_if, ucr_div and ucr_sqrt.

module ucr_back #(
    parameter int MAX_SAMPLES = ucr_pkg::MAX_SAMPLES_DEF,
    parameter int DW          = $clog2(MAX_SAMPLES),
    parameter int JW          = 3 * $bits(ucr_pkg::t_coef) + DW
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_pop_valid,
    output logic            o_pop_ready,
    input  logic [JW-1:0]   i_pop_data,
    ucr_sample_if.source    o_sample
);

    localparam int XW = 40 + 2 * DW;
    localparam int RW = 3 * DW + 1;
    localparam int QW = ucr_pkg::QUOT_W;

    localparam logic signed [QW-1:0] SAT_HI = QW'(32'h7FFF_FFFF);
    localparam logic signed [QW-1:0] SAT_LO = {{(QW - 32){1'b1}}, 32'h8000_0000};

    ucr_pkg::t_bstate     r_state;
    ucr_pkg::t_bstate     n_state;
    ucr_pkg::t_coef [2:0] r_coef;

    logic [DW-1:0]        r_d;
    logic [2*DW-1:0]      r_d2;
    logic [3*DW-1:0]      r_d3;
    logic [RW-1:0]        den;
    logic signed [DW:0]   ds;
    logic signed [XW-1:0] r_h [3];
    logic signed [XW-1:0] r_g [3];
    logic signed [XW-1:0] r_e [3];
    logic signed [XW-1:0] e6 [3];

    // M = N + D^3 and its differences, each as quotient and remainder by 2*D^3
    logic signed [QW-1:0] r_mq [3];
    logic signed [QW-1:0] r_1q [3];
    logic signed [QW-1:0] r_2q [3];
    logic signed [QW-1:0] r_3q [3];
    logic [RW-1:0]        r_mr [3];
    logic [RW-1:0]        r_1r [3];
    logic [RW-1:0]        r_2r [3];
    logic [RW-1:0]        r_3r [3];
    logic signed [QW-1:0] n_mq [3];
    logic signed [QW-1:0] n_1q [3];
    logic signed [QW-1:0] n_2q [3];
    logic [RW-1:0]        n_mr [3];
    logic [RW-1:0]        n_1r [3];
    logic [RW-1:0]        n_2r [3];

    logic [DW-1:0]        r_i;
    logic [DW+5:0]        i_ext;
    logic signed [31:0]   cur [3];
    logic signed [31:0]   r_cur [3];
    logic signed [31:0]   r_prev [3];
    logic [63:0]          r_sq [3];
    logic [63:0]          sq [3];
    logic [65:0]          sum;
    logic [31:0]          r_chord;

    logic                 r_ovalid;
    logic signed [31:0]   r_ox;
    logic signed [31:0]   r_oy;
    logic signed [31:0]   r_oz;
    logic [31:0]          r_olen;
    logic [5:0]           r_oidx;
    logic                 r_olast;

    logic                 div_start;
    logic [8:0]           div_done;
    logic signed [XW-1:0] div_num [9];
    logic signed [QW-1:0] div_q [9];
    logic [RW-1:0]        div_r [9];
    logic                 sqrt_start;
    logic                 sqrt_done;
    logic [31:0]          sqrt_root;
    logic                 out_free;
    logic                 out_load;
    logic                 last_i;

    assign den      = {r_d3, 1'b0};
    assign ds       = $signed({1'b0, r_d});
    assign i_ext    = {6'd0, r_i};
    assign last_i   = (r_i == r_d);
    assign out_free = !r_ovalid || o_sample.ready;
    assign sum      = 66'(r_sq[0]) + 66'(r_sq[1]) + 66'(r_sq[2]);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            e6[k] = (XW'(r_coef[k].d) <<< 2) + (XW'(r_coef[k].d) <<< 1);
        end
    end

    // three dividers per axis: first, second and third difference
    for (genvar k = 0; k < 3; k++) begin : g_axis
        assign div_num[3*k]     = r_h[k];
        assign div_num[3*k + 1] = r_g[k];
        assign div_num[3*k + 2] = r_e[k];
    end

    for (genvar j = 0; j < 9; j++) begin : g_div
        ucr_div #(.XW(XW), .RW(RW), .QW(QW)) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (div_start),
            .i_num   (div_num[j]),
            .i_den   (den),
            .o_done  (div_done[j]),
            .o_q     (div_q[j]),
            .o_r     (div_r[j])
        );
    end

    ucr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_val   (sum[63:0]),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    // sample value, rounding half away from zero, then stepping the differences
    always_comb begin
        logic                 neg;
        logic signed [QW-1:0] rnd;
        logic [RW:0]          s;
        logic                 w;
        for (int k = 0; k < 3; k++) begin
            neg = (r_mq[k] < 0) || ((r_mq[k] == '0) && (r_mr[k] < RW'(r_d3)));
            rnd = r_mq[k] - QW'(neg && (r_mr[k] == '0));
            if (rnd > SAT_HI) begin
                cur[k] = 32'sh7FFF_FFFF;
            end else if (rnd < SAT_LO) begin
                cur[k] = 32'sh8000_0000;
            end else begin
                cur[k] = rnd[31:0];
            end

            s = {1'b0, r_mr[k]} + {1'b0, r_1r[k]};
            w = (s >= {1'b0, den});
            n_mr[k] = w ? RW'(s - {1'b0, den}) : s[RW-1:0];
            n_mq[k] = r_mq[k] + r_1q[k] + QW'(w);

            s = {1'b0, r_1r[k]} + {1'b0, r_2r[k]};
            w = (s >= {1'b0, den});
            n_1r[k] = w ? RW'(s - {1'b0, den}) : s[RW-1:0];
            n_1q[k] = r_1q[k] + r_2q[k] + QW'(w);

            s = {1'b0, r_2r[k]} + {1'b0, r_3r[k]};
            w = (s >= {1'b0, den});
            n_2r[k] = w ? RW'(s - {1'b0, den}) : s[RW-1:0];
            n_2q[k] = r_2q[k] + r_3q[k] + QW'(w);
        end
    end

    always_comb begin
        logic signed [32:0] df;
        logic [31:0]        mag;
        for (int k = 0; k < 3; k++) begin
            df    = 33'(r_cur[k]) - 33'(r_prev[k]);
            mag   = df[32] ? 32'(-df) : df[31:0];
            sq[k] = mag * mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ucr_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_pop_ready = 1'b0;
        div_start   = 1'b0;
        sqrt_start  = 1'b0;
        out_load    = 1'b0;
        unique case (r_state)
            ucr_pkg::B_IDLE: begin
                o_pop_ready = 1'b1;
                if (i_pop_valid) begin
                    n_state = ucr_pkg::B_MUL1;
                end
            end
            ucr_pkg::B_MUL1:  n_state = ucr_pkg::B_MUL2;
            ucr_pkg::B_MUL2:  n_state = ucr_pkg::B_DIVST;
            ucr_pkg::B_DIVST: begin
                div_start = 1'b1;
                n_state   = ucr_pkg::B_DIV;
            end
            ucr_pkg::B_DIV: begin
                if (&div_done) begin
                    n_state = ucr_pkg::B_CALC;
                end
            end
            ucr_pkg::B_CALC:  n_state = ucr_pkg::B_SQ;
            ucr_pkg::B_SQ:    n_state = ucr_pkg::B_SUM;
            ucr_pkg::B_SUM: begin
                if (r_i == '0 || sum[65:64] != 2'b00) begin
                    n_state = ucr_pkg::B_OUT;
                end else begin
                    sqrt_start = 1'b1;
                    n_state    = ucr_pkg::B_ROOT;
                end
            end
            ucr_pkg::B_ROOT: begin
                if (sqrt_done) begin
                    n_state = ucr_pkg::B_OUT;
                end
            end
            ucr_pkg::B_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = last_i ? ucr_pkg::B_IDLE : ucr_pkg::B_CALC;
                end
            end
            default: n_state = ucr_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ucr_pkg::B_IDLE: begin
                {r_coef, r_d} <= i_pop_data;
            end
            ucr_pkg::B_MUL1: begin
                r_d2 <= r_d * r_d;
                for (int k = 0; k < 3; k++) begin
                    r_h[k] <= XW'(r_coef[k].b * ds) + XW'(r_coef[k].c);
                    r_g[k] <= XW'(r_coef[k].c * ds);
                end
            end
            ucr_pkg::B_MUL2: begin
                r_d3 <= r_d2 * r_d;
                for (int k = 0; k < 3; k++) begin
                    r_h[k] <= XW'(r_h[k] * ds) + XW'(r_coef[k].d);
                    r_g[k] <= (r_g[k] <<< 1) + e6[k];
                    r_e[k] <= e6[k];
                end
            end
            ucr_pkg::B_DIVST: begin
                // M(0) = (2*p1 + 1) * D^3 = p1 * den + D^3
                for (int k = 0; k < 3; k++) begin
                    r_mq[k] <= QW'(r_coef[k].p1);
                    r_mr[k] <= RW'(r_d3);
                end
            end
            ucr_pkg::B_DIV: begin
                r_i <= '0;
                for (int k = 0; k < 3; k++) begin
                    r_1q[k] <= div_q[3*k];
                    r_1r[k] <= div_r[3*k];
                    r_2q[k] <= div_q[3*k + 1];
                    r_2r[k] <= div_r[3*k + 1];
                    r_3q[k] <= div_q[3*k + 2];
                    r_3r[k] <= div_r[3*k + 2];
                end
            end
            ucr_pkg::B_CALC: begin
                for (int k = 0; k < 3; k++) begin
                    r_cur[k] <= cur[k];
                    r_mq[k]  <= n_mq[k];
                    r_mr[k]  <= n_mr[k];
                    r_1q[k]  <= n_1q[k];
                    r_1r[k]  <= n_1r[k];
                    r_2q[k]  <= n_2q[k];
                    r_2r[k]  <= n_2r[k];
                end
            end
            ucr_pkg::B_SQ: begin
                for (int k = 0; k < 3; k++) begin
                    r_sq[k] <= sq[k];
                end
            end
            ucr_pkg::B_SUM: begin
                if (r_i == '0) begin
                    r_chord <= '0;
                end else begin
                    r_chord <= 32'hFFFF_FFFF;
                end
            end
            ucr_pkg::B_ROOT: begin
                if (sqrt_done) begin
                    r_chord <= sqrt_root;
                end
            end
            ucr_pkg::B_OUT: begin
                if (out_free) begin
                    for (int k = 0; k < 3; k++) begin
                        r_prev[k] <= r_cur[k];
                    end
                    r_i <= r_i + DW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (o_sample.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_ox    <= r_cur[0];
            r_oy    <= r_cur[1];
            r_oz    <= r_cur[2];
            r_olen  <= r_chord;
            r_oidx  <= i_ext[5:0];
            r_olast <= last_i;
        end
    end

    assign o_sample.valid        = r_ovalid;
    assign o_sample.sample_x     = r_ox;
    assign o_sample.sample_y     = r_oy;
    assign o_sample.sample_z     = r_oz;
    assign o_sample.chord_length = r_olen;
    assign o_sample.sample_index = r_oidx;
    assign o_sample.last_sample  = r_olast;

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ucr_pkg::B_CALC) |->
            (r_mr[0] < den && r_mr[1] < den && r_mr[2] < den))
        else $error("running remainder not reduced below divisor");

    a_root_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sqrt_done |-> (r_state == ucr_pkg::B_ROOT))
        else $error("square root finished outside its wait state");

    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done[0] |-> (r_state == ucr_pkg::B_DIV))
        else $error("divider finished outside segment setup");

endmodule

FILE: src/uniform_catmull_rom_tessellator.sv
// Uniform Catmull-Rom tessellator, top level: front, job queue and back.
// Depends on ucr_pkg, ucr_if, ucr_front, ucr_fifo and ucr_back.
//
//  channel    dir  handshake        payload
//  i_point    in   valid/ready      point_x, point_y, point_z (Q16.16)
//  o_sample   out  valid/ready      sample_x/y/z, chord_length, sample_index,
//                                   last_sample
//  i_cfg_*    in   write enable     samples_per_segment (7 bits)
//
// The first three points only fill the window. Each later point pushes one
// segment job to the queue; the back end then runs a per-segment setup
// (bit-serial dividers), then steps each sample, dominated by the bit-serial
// square root, which the first sample of a segment skips. It takes a new
// job only once the last sample of the current one has been loaded.
// Reset is synchronous, active low; the window clears to zero.
// Either side may stall: the two-entry queue and the output register decouple them.

module uniform_catmull_rom_tessellator #(
    parameter int MAX_SAMPLES = ucr_pkg::MAX_SAMPLES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ucr_pkg::CFG_W-1:0]   i_cfg_wdata,
    ucr_point_if.sink                   i_point,
    ucr_sample_if.source                o_sample
);

    localparam int DW = $clog2(MAX_SAMPLES);
    localparam int JW = 3 * $bits(ucr_pkg::t_coef) + DW;

    logic          push_valid;
    logic          push_ready;
    logic [JW-1:0] push_data;
    logic          pop_valid;
    logic          pop_ready;
    logic [JW-1:0] pop_data;

    ucr_front #(.MAX_SAMPLES(MAX_SAMPLES), .DW(DW), .JW(JW)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_point      (i_point),
        .o_push_valid (push_valid),
        .o_push_data  (push_data),
        .i_push_ready (push_ready)
    );

    ucr_fifo #(.W(JW), .DEPTH(ucr_pkg::QUEUE_DEPTH)) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    ucr_back #(.MAX_SAMPLES(MAX_SAMPLES), .DW(DW), .JW(JW)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_data  (pop_data),
        .o_sample    (o_sample)
    );

endmodule
